[rtl/core/wsfe_pkg.sv]
// Shared types and constants for the WebSocket frame encoder.
package wsfe_pkg;

    // Input transaction layout (s_axis_tdata)
    localparam int IN_DATA_W  = 112;
    localparam int LEN_W      = 63;
    localparam int KEY_W      = 32;
    localparam int FIN_LSB    = 0;
    localparam int RSV_LSB    = 1;
    localparam int FTYPE_LSB  = 4;
    localparam int MASKED_LSB = 8;
    localparam int LEN_LSB    = 9;
    localparam int KEY_LSB    = 72;
    localparam int PBYTE_LSB  = 104;

    // Output transaction layout (m_axis_tuser)
    localparam int OUT_USER_W = 4;

    // Header index: at most 14 header bytes
    localparam int HIDX_W = 4;

    // Item kind carried in s_axis_tuser
    typedef enum logic [0:0] {
        KIND_START   = 1'b0,
        KIND_PAYLOAD = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_START_ERR = 2'd1,
        STATUS_NO_FRAME  = 2'd2
    } t_status;

    // Length encoding in the second header byte
    typedef enum logic [1:0] {
        LCLS_SHORT = 2'd0,  // 7-bit length in place
        LCLS_MID   = 2'd1,  // 126 + 16-bit length
        LCLS_LONG  = 2'd2   // 127 + 64-bit length
    } t_lcls;

    localparam logic [6:0] LEN_CODE_MID  = 7'd126;
    localparam logic [6:0] LEN_CODE_LONG = 7'd127;

    localparam logic [HIDX_W-1:0] EXT_MID  = 4'd2;
    localparam logic [HIDX_W-1:0] EXT_LONG = 4'd8;
    localparam logic [HIDX_W-1:0] KEY_BYTES = 4'd4;

    // Header byte request from the top level to the header generator
    typedef struct packed {
        logic              fin;
        logic [2:0]        rsv;
        logic [3:0]        ftype;
        logic              masked;
        t_lcls             lcls;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key;
        logic [HIDX_W-1:0] idx;
    } t_hdr_req;

endpackage

[rtl/core/wsfe_hdr_gen.sv]
// Header byte selector: returns header byte number idx of a frame.
module wsfe_hdr_gen (
    input  wsfe_pkg::t_hdr_req i_req,
    output logic [7:0]         o_byte
);

    logic [wsfe_pkg::HIDX_W-1:0] ext_n;
    logic [wsfe_pkg::HIDX_W-1:0] k_full;
    logic [1:0]                  j_full;
    logic [2:0]                  k_inv;
    logic [1:0]                  j_inv;
    logic [63:0]                 len64;
    logic [6:0]                  len_code;

    always_comb begin
        case (i_req.lcls)
            wsfe_pkg::LCLS_SHORT: begin
                ext_n    = '0;
                len_code = i_req.len[6:0];
            end
            wsfe_pkg::LCLS_MID: begin
                ext_n    = wsfe_pkg::EXT_MID;
                len_code = wsfe_pkg::LEN_CODE_MID;
            end
            default: begin
                ext_n    = wsfe_pkg::EXT_LONG;
                len_code = wsfe_pkg::LEN_CODE_LONG;
            end
        endcase
    end

    assign len64  = {1'b0, i_req.len};
    assign k_full = i_req.idx - 4'd2;
    // key byte number only needs two bits
    assign j_full = k_full[1:0] - ext_n[1:0];
    // big-endian: first extended byte is the most significant one
    assign k_inv  = (i_req.lcls == wsfe_pkg::LCLS_MID) ? (3'd1 - k_full[2:0])
                                                      : (3'd7 - k_full[2:0]);
    assign j_inv  = 2'd3 - j_full;

    always_comb begin
        if (i_req.idx == 4'd0) begin
            o_byte = {i_req.fin, i_req.rsv, i_req.ftype};
        end else if (i_req.idx == 4'd1) begin
            o_byte = {i_req.masked, len_code};
        end else if (k_full < ext_n) begin
            o_byte = 8'(len64 >> {k_inv, 3'b000});
        end else begin
            o_byte = 8'(i_req.key >> {j_inv, 3'b000});
        end
    end

endmodule

[rtl/core/websocket_frame_encoder_core.sv]
// WebSocket frame encoder top level: input register, frame state, output register.
// Each accepted transaction is held in the input register and its results are registered for m_axis.
// Throughput: one payload or error transaction per cycle while m_axis is not stalled; a start
// transaction sends its 2 to 14 header bytes one at a time over the single output byte lane.
// Reset (i_rst_n low, synchronous) empties both registers and closes any open frame.
module websocket_frame_encoder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // fin, rsv_bits[3], frame_type[4], masked, frame_len[63],
    // mask_key[32], payload_byte[8]
    input  logic [wsfe_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte
    output logic [7:0]                     m_axis_tdata,
    // has_byte, frame_end, status[2]
    output logic [wsfe_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);

    // input register
    logic                            r_item_valid;
    wsfe_pkg::t_kind                 r_kind;
    logic                            r_fin;
    logic [2:0]                      r_rsv;
    logic [3:0]                      r_ftype;
    logic                            r_masked;
    logic [wsfe_pkg::LEN_W-1:0]      r_len;
    logic [wsfe_pkg::KEY_W-1:0]      r_key;
    logic [7:0]                      r_pbyte;
    wsfe_pkg::t_lcls                 r_lcls;
    logic                            r_len_zero;
    logic [wsfe_pkg::HIDX_W-1:0]     r_nlast;
    logic [wsfe_pkg::HIDX_W-1:0]     r_hidx;

    // frame state
    logic                            r_frame_open;
    logic                            r_mask_enable;
    logic [wsfe_pkg::KEY_W-1:0]      r_key_store;
    logic [wsfe_pkg::LEN_W-1:0]      r_bytes_left;
    logic [1:0]                      r_key_index;

    // output register
    logic                            r_out_valid;
    logic [7:0]                      r_out_byte;
    logic                            r_out_has;
    logic                            r_out_end;
    logic                            r_out_last;
    wsfe_pkg::t_status               r_out_status;

    // result of the current step
    logic [7:0]                      n_byte;
    logic                            n_has;
    logic                            n_end;
    logic                            n_last;
    wsfe_pkg::t_status               n_status;

    logic                            out_load;
    logic                            step;
    logic                            done;
    logic                            s_accept;
    logic [wsfe_pkg::LEN_W-1:0]      in_len;
    logic                            in_masked;
    wsfe_pkg::t_lcls                 in_lcls;
    logic [wsfe_pkg::HIDX_W-1:0]     in_ext;
    wsfe_pkg::t_hdr_req              hdr_req;
    logic [7:0]                      hdr_byte;
    logic [7:0]                      key_byte;
    logic                            pay_end;

    assign out_load      = !r_out_valid || m_axis_tready;
    assign step          = r_item_valid && out_load;
    assign done          = step && n_last;
    assign s_axis_tready = !r_item_valid || done;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // length class worked out on the way into the input register
    assign in_len    = s_axis_tdata[wsfe_pkg::LEN_LSB +: wsfe_pkg::LEN_W];
    assign in_masked = s_axis_tdata[wsfe_pkg::MASKED_LSB];

    always_comb begin
        if (in_len < 63'd126) begin
            in_lcls = wsfe_pkg::LCLS_SHORT;
            in_ext  = '0;
        end else if (in_len[wsfe_pkg::LEN_W-1:16] == '0) begin
            in_lcls = wsfe_pkg::LCLS_MID;
            in_ext  = wsfe_pkg::EXT_MID;
        end else begin
            in_lcls = wsfe_pkg::LCLS_LONG;
            in_ext  = wsfe_pkg::EXT_LONG;
        end
    end

    assign hdr_req.fin    = r_fin;
    assign hdr_req.rsv    = r_rsv;
    assign hdr_req.ftype  = r_ftype;
    assign hdr_req.masked = r_masked;
    assign hdr_req.lcls   = r_lcls;
    assign hdr_req.len    = r_len;
    assign hdr_req.key    = r_key;
    assign hdr_req.idx    = r_hidx;

    wsfe_hdr_gen u_hdr_gen (
        .i_req  (hdr_req),
        .o_byte (hdr_byte)
    );

    assign key_byte = 8'(r_key_store >> {2'd3 - r_key_index, 3'b000});
    assign pay_end  = (r_bytes_left[wsfe_pkg::LEN_W-1:1] == '0);

    always_comb begin
        n_byte   = '0;
        n_has    = 1'b0;
        n_end    = 1'b0;
        n_last   = 1'b1;
        n_status = wsfe_pkg::STATUS_OK;
        if (r_kind == wsfe_pkg::KIND_START) begin
            if (r_frame_open) begin
                n_status = wsfe_pkg::STATUS_START_ERR;
            end else begin
                n_byte = hdr_byte;
                n_has  = 1'b1;
                n_last = (r_hidx == r_nlast);
                n_end  = n_last && r_len_zero;
            end
        end else begin
            if (!r_frame_open) begin
                n_status = wsfe_pkg::STATUS_NO_FRAME;
            end else begin
                n_byte = r_mask_enable ? (r_pbyte ^ key_byte) : r_pbyte;
                n_has  = 1'b1;
                n_end  = pay_end;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (s_accept) begin
            r_item_valid <= 1'b1;
        end else if (done) begin
            r_item_valid <= 1'b0;
        end
        if (s_accept) begin
            r_kind     <= wsfe_pkg::t_kind'(s_axis_tuser);
            r_fin      <= s_axis_tdata[wsfe_pkg::FIN_LSB];
            r_rsv      <= s_axis_tdata[wsfe_pkg::RSV_LSB +: 3];
            r_ftype    <= s_axis_tdata[wsfe_pkg::FTYPE_LSB +: 4];
            r_masked   <= in_masked;
            r_len      <= in_len;
            r_key      <= s_axis_tdata[wsfe_pkg::KEY_LSB +: wsfe_pkg::KEY_W];
            r_pbyte    <= s_axis_tdata[wsfe_pkg::PBYTE_LSB +: 8];
            r_lcls     <= in_lcls;
            r_len_zero <= (in_len == '0);
            r_nlast    <= 4'd1 + in_ext + (in_masked ? wsfe_pkg::KEY_BYTES : 4'd0);
        end
    end

    // header byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx <= '0;
        end else if (done) begin
            r_hidx <= '0;
        end else if (step) begin
            r_hidx <= r_hidx + 4'd1;
        end
    end

    // frame state, updated as a transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open  <= 1'b0;
            r_mask_enable <= 1'b0;
            r_key_store   <= '0;
            r_bytes_left  <= '0;
            r_key_index   <= '0;
        end else if (done && n_status == wsfe_pkg::STATUS_OK) begin
            if (r_kind == wsfe_pkg::KIND_START) begin
                if (!r_len_zero) begin
                    r_frame_open  <= 1'b1;
                    r_mask_enable <= r_masked;
                    r_key_store   <= r_key;
                    r_bytes_left  <= r_len;
                    r_key_index   <= '0;
                end
            end else begin
                r_key_index  <= r_key_index + 2'd1;
                r_bytes_left <= pay_end ? '0 : (r_bytes_left - 63'd1);
                if (pay_end) begin
                    r_frame_open <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_item_valid;
        end
        if (step) begin
            r_out_byte   <= n_byte;
            r_out_has    <= n_has;
            r_out_end    <= n_end;
            r_out_last   <= n_last;
            r_out_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = {r_out_status, r_out_end, r_out_has};
    assign m_axis_tlast  = r_out_last;

endmodule
